@@ sv/sorted_priority_queue_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared macros that wrap concurrent assertions in one house form.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Field widths, operation and status codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package spq_pkg;

   // Widths of the word fields.
   localparam int VALUE_W       = 32;
   localparam int ENTRY_COUNT_W = 5;

   // Operation carried by a request word.
   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   // Outcome reported in a response word.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;     // capture the accepted request word
      logic       ptr_load;     // hole pointer takes the entry count
      logic       ptr_dec;      // hole pointer moves down one slot
      logic       rd_en;        // issue a RAM read
      logic       rd_top;       // read the largest entry, else the slot below the hole
      logic       wr_en;        // write the RAM at the hole
      logic       wr_value;     // write the new value, else the entry just read
      logic       count_inc;
      logic       count_dec;
      logic       res_load;     // record the outcome of the operation
      logic       res_take;     // outcome carries the entry just read
      status_type res_status;
      logic       rsp_load;     // move the outcome into the response register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_remove;
      logic full;
      logic empty;
      logic ptr_zero;
      logic greater;            // entry just read is greater than the new value
   } dp_stat_type;

endpackage

@@ sv/spq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences insert and remove operations and owns the response valid flag.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_defines.svh"

module spq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output spq_pkg::ctrl_cmd_type dp_cmd,
   input  spq_pkg::dp_stat_type dp_stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_CHECK,
      S_COMPARE,
      S_REMOVE_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // The response register can take a new word when empty or being drained.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dp_cmd       = '0;
      dp_cmd.res_status = spq_pkg::STATUS_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load_req = 1'b1;
               state_in        = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (dp_stat.is_remove) begin
               if (dp_stat.empty) begin
                  dp_cmd.res_load   = 1'b1;
                  dp_cmd.res_status = spq_pkg::STATUS_EMPTY;
                  state_in          = S_FINISH;
               end else begin
                  dp_cmd.rd_en  = 1'b1;
                  dp_cmd.rd_top = 1'b1;
                  state_in      = S_REMOVE_WAIT;
               end
            end else begin
               if (dp_stat.full) begin
                  dp_cmd.res_load   = 1'b1;
                  dp_cmd.res_status = spq_pkg::STATUS_FULL;
                  state_in          = S_FINISH;
               end else begin
                  dp_cmd.ptr_load = 1'b1;
                  state_in        = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            // At the bottom slot the value goes in; otherwise look one slot down.
            if (dp_stat.ptr_zero) begin
               dp_cmd.wr_en     = 1'b1;
               dp_cmd.wr_value  = 1'b1;
               dp_cmd.count_inc = 1'b1;
               dp_cmd.res_load  = 1'b1;
               state_in         = S_FINISH;
            end else begin
               dp_cmd.rd_en = 1'b1;
               state_in     = S_COMPARE;
            end
         end
         S_COMPARE: begin
            // A greater entry moves up into the hole; else the value fills it.
            if (dp_stat.greater) begin
               dp_cmd.wr_en   = 1'b1;
               dp_cmd.ptr_dec = 1'b1;
               state_in       = S_CHECK;
            end else begin
               dp_cmd.wr_en     = 1'b1;
               dp_cmd.wr_value  = 1'b1;
               dp_cmd.count_inc = 1'b1;
               dp_cmd.res_load  = 1'b1;
               state_in         = S_FINISH;
            end
         end
         S_REMOVE_WAIT: begin
            dp_cmd.res_load  = 1'b1;
            dp_cmd.res_take  = 1'b1;
            dp_cmd.count_dec = 1'b1;
            state_in         = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               dp_cmd.rsp_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // No storage write may happen while a new word can be taken.
   `SPQ_ASSERT_NOW(a_idle_no_write, clock, reset, req_ready, !dp_cmd.wr_en, "RAM write while idle")

   // A finished operation delivers its word and returns to idle.
   `SPQ_ASSERT_NEXT(a_finish_delivers, clock, reset, state_ff == S_FINISH && rsp_free, rsp_valid_ff && state_ff == S_IDLE, "finished word not delivered")

endmodule

@@ sv/spq_dp.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Entry RAM in ascending order, entry count, hole pointer and response words.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_defines.svh"

module spq_dp #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_cmd,
   input  logic signed [spq_pkg::VALUE_W-1:0] req_value,
   output logic signed [spq_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [1:0]                         rsp_status,
   output logic [spq_pkg::ENTRY_COUNT_W-1:0]  rsp_entry_count,
   input  spq_pkg::ctrl_cmd_type              dp_cmd,
   output spq_pkg::dp_stat_type               dp_stat
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WIDE_W = CNT_W + spq_pkg::ENTRY_COUNT_W;

   spq_pkg::op_type                     op_ff, op_in;
   logic signed [spq_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [IDX_W-1:0]                    ptr_ff, ptr_in;
   spq_pkg::status_type                 res_status_ff, res_status_in;
   logic signed [spq_pkg::VALUE_W-1:0]  res_removed_ff, res_removed_in;
   logic signed [spq_pkg::VALUE_W-1:0]  rsp_removed_ff, rsp_removed_in;
   spq_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic [spq_pkg::ENTRY_COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [CNT_W-1:0]            count_less;
   logic [WIDE_W-1:0]           count_wide;
   logic [IDX_W-1:0]            rd_addr;
   logic [IDX_W-1:0]            ptr_less;
   logic [spq_pkg::VALUE_W-1:0] rd_data;
   logic [spq_pkg::VALUE_W-1:0] wr_data;

   // Entries sit in ascending order: the largest is at slot count minus one.
   assign count_less = count_ff - CNT_W'(1);
   assign ptr_less   = ptr_ff - IDX_W'(1);
   assign rd_addr    = dp_cmd.rd_top ? count_less[IDX_W-1:0] : ptr_less;
   assign wr_data    = dp_cmd.wr_value ? value_ff : rd_data;
   assign count_wide = WIDE_W'(count_ff);

   spq_ram #(
      .WIDTH (spq_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (dp_cmd.wr_en),
      .wr_addr (ptr_ff),
      .wr_data (wr_data),
      .rd_en   (dp_cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Status toward the controller.
   always_comb begin
      dp_stat.is_remove = (op_ff == spq_pkg::OP_REMOVE);
      dp_stat.full      = (count_ff == CNT_W'(CAPACITY));
      dp_stat.empty     = (count_ff == '0);
      dp_stat.ptr_zero  = (ptr_ff == '0);
      dp_stat.greater   = ($signed(rd_data) > value_ff);
   end

   // Next values of the datapath registers.
   always_comb begin
      op_in          = op_ff;
      value_in       = value_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      res_status_in  = res_status_ff;
      res_removed_in = res_removed_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      if (dp_cmd.load_req) begin
         op_in    = spq_pkg::op_type'(req_cmd);
         value_in = req_value;
      end
      if (dp_cmd.ptr_load) begin
         ptr_in = count_ff[IDX_W-1:0];
      end else if (dp_cmd.ptr_dec) begin
         ptr_in = ptr_less;
      end
      if (dp_cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (dp_cmd.count_dec) begin
         count_in = count_less;
      end
      if (dp_cmd.res_load) begin
         res_status_in  = dp_cmd.res_status;
         res_removed_in = dp_cmd.res_take ? $signed(rd_data) : '0;
      end
      if (dp_cmd.rsp_load) begin
         rsp_removed_in = res_removed_ff;
         rsp_status_in  = res_status_ff;
         rsp_count_in   = count_wide[spq_pkg::ENTRY_COUNT_W-1:0];
      end
   end

   // Only the entry count needs a reset; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      op_ff          <= op_in;
      value_ff       <= value_in;
      ptr_ff         <= ptr_in;
      res_status_ff  <= res_status_in;
      res_removed_ff <= res_removed_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = rsp_count_ff;

   // The count never passes the capacity.
   `SPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "entry count above capacity")

   // Writes land inside the live region or at the slot just above it.
   `SPQ_ASSERT_NOW(a_write_in_range, clock, reset, dp_cmd.wr_en, ptr_ff <= count_ff, "write beyond live entries")

endmodule

@@ sv/sorted_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded max-priority queue of signed words kept in sorted order in a RAM.
// ----------------------------------------------------------------------------
// One request word is handled at a time. After a request word is accepted,
// a remove reads the largest entry, records it and then delivers the response
// word; a refused insert or a refused remove records its status and delivers
// the response word. For an insert, the entries are held in ascending order
// in a RAM with one read port and registered read data; each stored entry
// greater than the new value is read and moved up one slot, and, unless every
// stored entry is greater (also for an empty queue), a final read and compare
// find the slot of the new value. req_ready rises in the cycle the response
// word appears, so the next request word can be taken from that cycle on.
// Among equal values the newest comes out first. The response register lets
// the next request word be taken while a finished response word still waits
// on rsp_ready; only the finish step of the next operation waits for it. The
// RAM needs no clearing after reset; the queue is empty as soon as reset is
// released.
module sorted_priority_queue_unit #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_cmd,
   input  logic signed [spq_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [spq_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [1:0]                         rsp_status,
   output logic [spq_pkg::ENTRY_COUNT_W-1:0]  rsp_entry_count
);

   spq_pkg::ctrl_cmd_type dp_cmd;
   spq_pkg::dp_stat_type  dp_stat;

   // Operation sequencer.
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   // Entry storage and response words.
   spq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_cmd),
      .req_value         (req_value),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .dp_cmd            (dp_cmd),
      .dp_stat           (dp_stat)
   );

endmodule
